>>> rtl/core/nrsa_pkg.sv
// Package for the nearest resize source address unit: widths, pipeline stage
// numbering, register and mode codes, the configuration struct and size helpers.
// No dependencies.
package nrsa_pkg;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned MAX_CHANNELS  = 1024;
  localparam int unsigned MAX_BATCH     = 64;
  localparam int unsigned CHANNEL_BLOCK = 8;

  localparam int unsigned SIZE_W    = 13;
  localparam int unsigned CH_W      = 11;
  localparam int unsigned BATCH_W   = $clog2(MAX_BATCH);
  localparam int unsigned CIDX_W    = 10;
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned INDEX_W   = 46;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CBLK_W    = $clog2(CHANNEL_BLOCK);
  localparam int unsigned GROUP_W   = CH_W - CBLK_W;

  // divider: numerator (2h+1)*I fits 26 bits, divisor 2*O fits 14 bits
  localparam int unsigned NUM_W      = 26;
  localparam int unsigned DEN_W      = 14;
  localparam int unsigned DIV_BITS   = 3;
  localparam int unsigned DIV_STAGES = COORD_W / DIV_BITS;

  // index datapath widths
  localparam int unsigned BASE_W = 16;
  localparam int unsigned T1_W   = 28;
  localparam int unsigned T2_W   = 41;

  // pipeline stage numbers
  localparam int unsigned ST_IN      = 0;
  localparam int unsigned ST_SETUP   = 1;
  localparam int unsigned ST_DIV0    = 2;
  localparam int unsigned ST_CLAMP   = ST_DIV0 + DIV_STAGES;
  localparam int unsigned ST_MUL     = ST_CLAMP + 1;
  localparam int unsigned ST_OUT     = ST_MUL + 1;
  localparam int unsigned NUM_STAGES = ST_OUT + 1;

  typedef logic [NUM_STAGES-1:0] stage_en_t;

  typedef enum logic [1:0] {
    MODE_HALF_PIXEL    = 2'd0,
    MODE_PYTORCH_HALF  = 2'd1,
    MODE_ALIGN_CORNERS = 2'd2,
    MODE_ASYMMETRIC    = 2'd3
  } coord_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT   = 3'd0,
    REG_IN_WIDTH    = 3'd1,
    REG_OUT_HEIGHT  = 3'd2,
    REG_OUT_WIDTH   = 3'd3,
    REG_IN_CHANNELS = 3'd4,
    REG_COORD_MODE  = 3'd5,
    REG_IN_BLOCKED  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  in_height;
    logic [SIZE_W-1:0]  in_width;
    logic [SIZE_W-1:0]  out_height;
    logic [SIZE_W-1:0]  out_width;
    logic [COORD_W-1:0] in_height_m1;
    logic [COORD_W-1:0] in_width_m1;
    logic [CH_W-1:0]    in_channels;
    coord_mode_t        coord_mode;
    logic               in_blocked;
  } cfg_t;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic logic [SIZE_W-1:0] sat_dim(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_DIM)) begin
      r = SIZE_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] sat_chan(input logic [CH_W-1:0] v);
    logic [CH_W-1:0] r;
    if (v == '0) begin
      r = CH_W'(1);
    end else if (v > CH_W'(MAX_CHANNELS)) begin
      r = CH_W'(MAX_CHANNELS);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/nrsa_if.sv
// Valid/ready channel interfaces for the nearest resize source address unit:
// one for the output pixel position word, one for the source address word.
// Depends on nrsa_pkg.
interface nrsa_in_if;
  logic                           valid;
  logic                           ready;
  logic [nrsa_pkg::BATCH_W-1:0]   batch_idx;
  logic [nrsa_pkg::CIDX_W-1:0]    chan_idx;
  logic [nrsa_pkg::COORD_W-1:0]   out_row;
  logic [nrsa_pkg::COORD_W-1:0]   out_col;

  modport source (output valid, batch_idx, chan_idx, out_row, out_col, input ready);
  modport sink   (input valid, batch_idx, chan_idx, out_row, out_col, output ready);
endinterface

interface nrsa_out_if;
  logic                           valid;
  logic                           ready;
  logic [nrsa_pkg::INDEX_W-1:0]   src_index;
  logic [nrsa_pkg::COORD_W-1:0]   src_row;
  logic [nrsa_pkg::COORD_W-1:0]   src_col;

  modport source (output valid, src_index, src_row, src_col, input ready);
  modport sink   (input valid, src_index, src_row, src_col, output ready);
endinterface

>>> rtl/core/nrsa_cfg.sv
// Configuration registers of the resize address unit. Sizes are saturated on
// write, and the last valid row and column are kept ready for clamping.
// Depends on nrsa_pkg.
module nrsa_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [nrsa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nrsa_pkg::SIZE_W-1:0]      cfg_wdata,
  output nrsa_pkg::cfg_t                   cfg
);

  nrsa_pkg::cfg_t cfg_r;
  nrsa_pkg::cfg_t cfg_nxt;

  always_comb begin
    logic [nrsa_pkg::SIZE_W-1:0]  dim;
    logic [nrsa_pkg::COORD_W-1:0] dim_m1;
    dim     = nrsa_pkg::sat_dim(cfg_wdata);
    dim_m1  = nrsa_pkg::COORD_W'(dim - nrsa_pkg::SIZE_W'(1));
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (nrsa_pkg::cfg_reg_t'(cfg_index))
        nrsa_pkg::REG_IN_HEIGHT: begin
          cfg_nxt.in_height    = dim;
          cfg_nxt.in_height_m1 = dim_m1;
        end
        nrsa_pkg::REG_IN_WIDTH: begin
          cfg_nxt.in_width    = dim;
          cfg_nxt.in_width_m1 = dim_m1;
        end
        nrsa_pkg::REG_OUT_HEIGHT: cfg_nxt.out_height = dim;
        nrsa_pkg::REG_OUT_WIDTH:  cfg_nxt.out_width  = dim;
        nrsa_pkg::REG_IN_CHANNELS: begin
          cfg_nxt.in_channels = nrsa_pkg::sat_chan(cfg_wdata[nrsa_pkg::CH_W-1:0]);
        end
        nrsa_pkg::REG_COORD_MODE: begin
          cfg_nxt.coord_mode = nrsa_pkg::coord_mode_t'(cfg_wdata[1:0]);
        end
        nrsa_pkg::REG_IN_BLOCKED: cfg_nxt.in_blocked = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.in_height    <= nrsa_pkg::SIZE_W'(1);
      cfg_r.in_width     <= nrsa_pkg::SIZE_W'(1);
      cfg_r.out_height   <= nrsa_pkg::SIZE_W'(1);
      cfg_r.out_width    <= nrsa_pkg::SIZE_W'(1);
      cfg_r.in_height_m1 <= '0;
      cfg_r.in_width_m1  <= '0;
      cfg_r.in_channels  <= nrsa_pkg::CH_W'(1);
      cfg_r.coord_mode   <= nrsa_pkg::MODE_HALF_PIXEL;
      cfg_r.in_blocked   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/core/nrsa_axis.sv
// One axis of the coordinate transform: input register, mode setup with one
// multiply, a pipelined restoring divider and the final clamp.
// Depends on nrsa_pkg.
module nrsa_axis (
  input  logic                            clk,
  input  nrsa_pkg::stage_en_t             ld,
  input  logic [nrsa_pkg::COORD_W-1:0]    coord,
  input  logic [nrsa_pkg::SIZE_W-1:0]     isz,
  input  logic [nrsa_pkg::SIZE_W-1:0]     osz,
  input  logic [nrsa_pkg::COORD_W-1:0]    lim,
  input  nrsa_pkg::coord_mode_t           mode,
  output logic [nrsa_pkg::COORD_W-1:0]    src
);

  localparam int unsigned NUM_W   = nrsa_pkg::NUM_W;
  localparam int unsigned DEN_W   = nrsa_pkg::DEN_W;
  localparam int unsigned SIZE_W  = nrsa_pkg::SIZE_W;
  localparam int unsigned COORD_W = nrsa_pkg::COORD_W;
  localparam int unsigned NDIV    = nrsa_pkg::DIV_STAGES;
  localparam int unsigned NBITS   = nrsa_pkg::DIV_BITS;

  logic [COORD_W-1:0] coord_r;

  // setup results
  logic [NUM_W-1:0]   num_nxt;
  logic [DEN_W-1:0]   den_nxt;
  logic               zero_nxt;

  // divider pipeline; index d feeds divider stage d
  logic [NUM_W-1:0]   rem_r  [0:NDIV-1];
  logic [DEN_W-1:0]   den_r  [0:NDIV-1];
  logic               zero_r [0:NDIV];
  logic               ovf_r  [1:NDIV];
  logic [COORD_W-1:0] quo_r  [1:NDIV];

  logic [COORD_W-1:0] src_r;
  logic [COORD_W-1:0] src_nxt;

  always_ff @(posedge clk) begin
    if (ld[nrsa_pkg::ST_IN]) begin
      coord_r <= coord;
    end
  end

  // (2h+1)*I - O over 2*O for the half-pixel modes, h*(I-1) over O-1 for
  // align corners, h*I over O for asymmetric
  always_comb begin
    logic [SIZE_W-1:0] mul_a;
    logic [SIZE_W-1:0] mul_b;
    logic [NUM_W-1:0]  prod;
    logic [NUM_W-1:0]  sub;
    logic              osz_one;
    osz_one  = (osz == SIZE_W'(1));
    mul_a    = {1'b0, coord_r};
    mul_b    = isz;
    sub      = '0;
    den_nxt  = DEN_W'(osz);
    zero_nxt = 1'b0;
    case (mode)
      nrsa_pkg::MODE_HALF_PIXEL, nrsa_pkg::MODE_PYTORCH_HALF: begin
        mul_a   = {coord_r, 1'b1};
        sub     = NUM_W'(osz);
        den_nxt = {osz, 1'b0};
        if (mode == nrsa_pkg::MODE_PYTORCH_HALF && osz_one) begin
          zero_nxt = 1'b1;
        end
      end
      nrsa_pkg::MODE_ALIGN_CORNERS: begin
        mul_b    = isz - SIZE_W'(1);
        den_nxt  = DEN_W'(osz - SIZE_W'(1));
        zero_nxt = osz_one;
      end
      nrsa_pkg::MODE_ASYMMETRIC: ;
      default: ;
    endcase
    prod    = NUM_W'(mul_a) * NUM_W'(mul_b);
    num_nxt = prod - sub;
    if (prod < sub) begin
      zero_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[nrsa_pkg::ST_SETUP]) begin
      rem_r[0]  <= num_nxt;
      den_r[0]  <= den_nxt;
      zero_r[0] <= zero_nxt;
    end
  end

  for (genvar d = 0; d < NDIV; d++) begin : g_div
    logic [NUM_W-1:0]   rem_nxt;
    logic [COORD_W-1:0] quo_nxt;
    logic [COORD_W-1:0] quo_in;

    if (d == 0) begin : g_first
      logic ovf_nxt;
      assign quo_in = '0;
      // quotient of 4096 or more saturates at the last input line anyway
      assign ovf_nxt = (rem_r[0] >= (NUM_W'(den_r[0]) << COORD_W));
      always_ff @(posedge clk) begin
        if (ld[nrsa_pkg::ST_DIV0]) begin
          ovf_r[1] <= ovf_nxt;
        end
      end
    end else begin : g_rest
      assign quo_in = quo_r[d];
      always_ff @(posedge clk) begin
        if (ld[nrsa_pkg::ST_DIV0 + d]) begin
          ovf_r[d+1] <= ovf_r[d];
        end
      end
    end

    always_comb begin
      logic [NUM_W-1:0] r;
      logic [NUM_W-1:0] trial;
      r       = rem_r[d];
      quo_nxt = quo_in;
      for (int k = 0; k < NBITS; k++) begin
        trial = NUM_W'(den_r[d]) << (COORD_W - 1 - d * NBITS - k);
        if (r >= trial) begin
          r = r - trial;
          quo_nxt[COORD_W - 1 - d * NBITS - k] = 1'b1;
        end
      end
      rem_nxt = r;
    end

    always_ff @(posedge clk) begin
      if (ld[nrsa_pkg::ST_DIV0 + d]) begin
        quo_r[d+1]  <= quo_nxt;
        zero_r[d+1] <= zero_r[d];
      end
    end

    if (d < NDIV - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ld[nrsa_pkg::ST_DIV0 + d]) begin
          rem_r[d+1] <= rem_nxt;
          den_r[d+1] <= den_r[d];
        end
      end
    end
  end

  always_comb begin
    if (zero_r[NDIV]) begin
      src_nxt = '0;
    end else if (ovf_r[NDIV] || (quo_r[NDIV] > lim)) begin
      src_nxt = lim;
    end else begin
      src_nxt = quo_r[NDIV];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[nrsa_pkg::ST_CLAMP]) begin
      src_r <= src_nxt;
    end
  end

  assign src = src_r;

endmodule

>>> rtl/core/nrsa_index.sv
// Flat source index for plain NCHW or 8-channel blocked layout. The batch and
// channel part is multiplied out while the dividers run. Depends on nrsa_pkg.
module nrsa_index (
  input  logic                            clk,
  input  nrsa_pkg::stage_en_t             ld,
  input  nrsa_pkg::cfg_t                  cfg,
  input  logic [nrsa_pkg::BATCH_W-1:0]    batch_idx,
  input  logic [nrsa_pkg::CIDX_W-1:0]     chan_idx,
  input  logic [nrsa_pkg::COORD_W-1:0]    row,
  input  logic [nrsa_pkg::COORD_W-1:0]    col,
  output logic [nrsa_pkg::INDEX_W-1:0]    src_index,
  output logic [nrsa_pkg::COORD_W-1:0]    src_row,
  output logic [nrsa_pkg::COORD_W-1:0]    src_col
);

  localparam int unsigned BASE_W  = nrsa_pkg::BASE_W;
  localparam int unsigned T1_W    = nrsa_pkg::T1_W;
  localparam int unsigned T2_W    = nrsa_pkg::T2_W;
  localparam int unsigned CBLK_W  = nrsa_pkg::CBLK_W;
  localparam int unsigned CIDX_W  = nrsa_pkg::CIDX_W;
  localparam int unsigned CH_W    = nrsa_pkg::CH_W;
  localparam int unsigned COORD_W = nrsa_pkg::COORD_W;
  localparam int unsigned INDEX_W = nrsa_pkg::INDEX_W;

  logic [nrsa_pkg::BATCH_W-1:0] batch_r;
  logic [CIDX_W-1:0]            chan_r;

  logic [BASE_W-1:0]            base_r;
  logic [BASE_W-1:0]            base_nxt;
  logic [CBLK_W-1:0]            clo_r [nrsa_pkg::ST_SETUP:nrsa_pkg::ST_MUL];

  logic [T1_W-1:0]              t1_r [nrsa_pkg::ST_DIV0:nrsa_pkg::ST_CLAMP];
  logic [T1_W-1:0]              t1_nxt;

  logic [T2_W-1:0]              t2_r;
  logic [T2_W-1:0]              t2_nxt;
  logic [COORD_W-1:0]           mul_row_r;
  logic [COORD_W-1:0]           mul_col_r;

  logic [INDEX_W-1:0]           src_index_r;
  logic [INDEX_W-1:0]           src_index_nxt;
  logic [COORD_W-1:0]           src_row_r;
  logic [COORD_W-1:0]           src_col_r;

  always_ff @(posedge clk) begin
    if (ld[nrsa_pkg::ST_IN]) begin
      batch_r <= batch_idx;
      chan_r  <= chan_idx;
    end
  end

  // blocked: b*(C/8) + c/8, plain: b*C + c
  always_comb begin
    if (cfg.in_blocked) begin
      base_nxt = BASE_W'(batch_r) * BASE_W'(cfg.in_channels[CH_W-1:CBLK_W])
               + BASE_W'(chan_r[CIDX_W-1:CBLK_W]);
    end else begin
      base_nxt = BASE_W'(batch_r) * BASE_W'(cfg.in_channels) + BASE_W'(chan_r);
    end
  end

  assign t1_nxt = T1_W'(base_r) * T1_W'(cfg.in_height);

  always_comb begin
    logic [T1_W-1:0] line;
    line   = t1_r[nrsa_pkg::ST_CLAMP] + T1_W'(row);
    t2_nxt = T2_W'(line) * T2_W'(cfg.in_width);
  end

  always_comb begin
    logic [T2_W-1:0] pix;
    pix = t2_r + T2_W'(mul_col_r);
    if (cfg.in_blocked) begin
      src_index_nxt = INDEX_W'({pix, clo_r[nrsa_pkg::ST_MUL]});
    end else begin
      src_index_nxt = INDEX_W'(pix);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[nrsa_pkg::ST_SETUP]) begin
      base_r                   <= base_nxt;
      clo_r[nrsa_pkg::ST_SETUP] <= chan_r[CBLK_W-1:0];
    end
    for (int s = nrsa_pkg::ST_SETUP + 1; s <= nrsa_pkg::ST_MUL; s++) begin
      if (ld[s]) begin
        clo_r[s] <= clo_r[s-1];
      end
    end
    if (ld[nrsa_pkg::ST_DIV0]) begin
      t1_r[nrsa_pkg::ST_DIV0] <= t1_nxt;
    end
    for (int s = nrsa_pkg::ST_DIV0 + 1; s <= nrsa_pkg::ST_CLAMP; s++) begin
      if (ld[s]) begin
        t1_r[s] <= t1_r[s-1];
      end
    end
    if (ld[nrsa_pkg::ST_MUL]) begin
      t2_r      <= t2_nxt;
      mul_row_r <= row;
      mul_col_r <= col;
    end
    if (ld[nrsa_pkg::ST_OUT]) begin
      src_index_r <= src_index_nxt;
      src_row_r   <= mul_row_r;
      src_col_r   <= mul_col_r;
    end
  end

  assign src_index = src_index_r;
  assign src_row   = src_row_r;
  assign src_col   = src_col_r;

endmodule

>>> rtl/core/nearest_resize_source_address_unit.sv
// Top level of the nearest resize source address unit: configuration, two
// axis transforms, index datapath and the stage valid/ready chain.
// Depends on nrsa_pkg, nrsa_if, nrsa_cfg, nrsa_axis, nrsa_index.
//
//   channel   dir  handshake        word
//   in_chan   in   valid/ready      batch_idx, chan_idx, out_row, out_col
//   out_chan  out  valid/ready      src_index, src_row, src_col
//   cfg_*     in   cfg_we only      cfg_index, cfg_wdata
//
// Nine register stages: input, mode setup (one multiply), four divider stages
// of three quotient bits each, clamp, row/width multiply, output add.
// One word per cycle while out_chan is not stalled.
// Reset empties the pipeline and loads sizes of 1, half-pixel mode, NCHW.
// Each stage holds while the one after it is full and stalled; empty stages
// fill up, so in_chan.ready stays high until the whole pipeline is full.
module nearest_resize_source_address_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  nrsa_in_if.sink                           in_chan,
  nrsa_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [nrsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nrsa_pkg::SIZE_W-1:0]       cfg_wdata
);

  localparam int unsigned NST = nrsa_pkg::NUM_STAGES;

  nrsa_pkg::cfg_t                 cfg;
  nrsa_pkg::stage_en_t            ld;
  logic [NST:0]                   rdy;
  logic [NST-1:0]                 valid_r;
  logic [NST-1:0]                 valid_nxt;
  logic [nrsa_pkg::COORD_W-1:0]   row;
  logic [nrsa_pkg::COORD_W-1:0]   col;

  nrsa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // a stage may load when it is empty or the stage after it moves
  always_comb begin
    rdy[NST] = out_chan.ready;
    for (int s = NST - 1; s >= 0; s--) begin
      rdy[s] = !valid_r[s] || rdy[s+1];
    end
    valid_nxt = valid_r;
    if (rdy[0]) begin
      valid_nxt[0] = in_chan.valid;
    end
    for (int s = 1; s < NST; s++) begin
      if (rdy[s]) begin
        valid_nxt[s] = valid_r[s-1];
      end
    end
  end

  assign ld = rdy[NST-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  nrsa_axis u_axis_row (
    .clk   (clk),
    .ld    (ld),
    .coord (in_chan.out_row),
    .isz   (cfg.in_height),
    .osz   (cfg.out_height),
    .lim   (cfg.in_height_m1),
    .mode  (cfg.coord_mode),
    .src   (row)
  );

  nrsa_axis u_axis_col (
    .clk   (clk),
    .ld    (ld),
    .coord (in_chan.out_col),
    .isz   (cfg.in_width),
    .osz   (cfg.out_width),
    .lim   (cfg.in_width_m1),
    .mode  (cfg.coord_mode),
    .src   (col)
  );

  nrsa_index u_index (
    .clk       (clk),
    .ld        (ld),
    .cfg       (cfg),
    .batch_idx (in_chan.batch_idx),
    .chan_idx  (in_chan.chan_idx),
    .row       (row),
    .col       (col),
    .src_index (out_chan.src_index),
    .src_row   (out_chan.src_row),
    .src_col   (out_chan.src_col)
  );

  assign in_chan.ready  = rdy[0];
  assign out_chan.valid = valid_r[nrsa_pkg::ST_OUT];

endmodule
